/* rtl/kct_pkg.sv */
// kct_pkg: shared types, sizes and codes for the keyed counter table.
// Used by kct_cell and keyed_counter_table; depends on nothing.
package kct_pkg;

    localparam int ENTRIES   = 16;
    localparam int KEY_CHARS = 8;

    localparam int KEY_W   = 64;
    localparam int QTY_W   = 32;
    localparam int COUNT_W = 5;                      // width of entry_count field
    localparam int CNT_W   = $clog2(ENTRIES + 1);    // width of the fill counter

    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_CHARS);

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_LOOKUP = 2'd2
    } req_code_t;

    typedef enum logic [2:0] {
        ST_ACCUM    = 3'd0,
        ST_INSERT   = 3'd1,
        ST_FULL     = 3'd2,
        ST_REMOVED  = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_FOUND    = 3'd5
    } status_code_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [KEY_W-1:0]        key;
        logic signed [QTY_W-1:0] amount;
    } req_t;

    typedef struct packed {
        logic [2:0]              status;
        logic signed [QTY_W-1:0] quantity;
        logic [COUNT_W-1:0]      entry_count;
    } rsp_t;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic valid;    // cell lies below the fill count
        logic ins_wr;   // cell takes the new entry
        logic acc_wr;   // matching cell takes the accumulated quantity
        logic rem_go;   // remove in progress: cells at and above the hit shift down
    } cell_ctl_t;

endpackage

/* rtl/kct_cell.sv */
// kct_cell: one table entry (key and quantity) with its own key compare.
// Depends on kct_pkg; chained by keyed_counter_table.
module kct_cell (
    input  logic                              clk,
    input  kct_pkg::cell_ctl_t                ctl,
    input  logic [kct_pkg::KEY_W-1:0]         cmd_key,
    input  logic signed [kct_pkg::QTY_W-1:0]  wr_qty,
    input  logic [kct_pkg::KEY_W-1:0]         nb_key,
    input  logic signed [kct_pkg::QTY_W-1:0]  nb_qty,
    input  logic                              hit_below,
    output logic                              hit_thru,
    output logic                              match,
    output logic [kct_pkg::KEY_W-1:0]         key,
    output logic signed [kct_pkg::QTY_W-1:0]  qty,
    output logic signed [kct_pkg::QTY_W-1:0]  qty_hit
);

    logic [kct_pkg::KEY_W-1:0]        key_reg;
    logic signed [kct_pkg::QTY_W-1:0] qty_reg;
    logic                             shift;

    assign match    = ctl.valid && (key_reg == cmd_key);
    assign hit_thru = hit_below || match;
    assign shift    = ctl.rem_go && hit_thru;
    assign key      = key_reg;
    assign qty      = qty_reg;
    assign qty_hit  = match ? qty_reg : '0;

    // Take the upper neighbor on a remove, the new entry on insert,
    // the new sum on a hit.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg <= nb_key;
            qty_reg <= nb_qty;
        end
        else if (ctl.ins_wr)
        begin
            key_reg <= cmd_key;
            qty_reg <= wr_qty;
        end
        else if (ctl.acc_wr && match)
        begin
            qty_reg <= wr_qty;
        end
    end

endmodule

/* rtl/keyed_counter_table.sv */
// keyed_counter_table: compact table of unique keys with saturating signed counts.
// A word is captured, then compare-and-update runs in all cells in the execute state and
// registers the result; execute waits on an unread result, and no new word enters meanwhile.
// Reset: rst_n (async, low) empties the table; cell contents are left as they are.
// Depends on kct_pkg and kct_cell.
module keyed_counter_table (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  kct_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output kct_pkg::rsp_t rsp
);

    // ------------------------------------------------------------------
    // Sequencer state, command capture, fill count and result register
    // ------------------------------------------------------------------
    kct_pkg::state_t            state_reg, state_next;
    kct_pkg::req_t              cmd_reg;
    logic [kct_pkg::CNT_W-1:0]  count_reg, count_next;
    kct_pkg::rsp_t              rsp_reg, rsp_next;
    logic                       rsp_valid_reg, rsp_valid_next;

    // Chain wiring between cells
    kct_pkg::cell_ctl_t               cell_ctl  [kct_pkg::ENTRIES];
    logic [kct_pkg::KEY_W-1:0]        cell_key  [kct_pkg::ENTRIES];
    logic signed [kct_pkg::QTY_W-1:0] cell_qty  [kct_pkg::ENTRIES];
    logic signed [kct_pkg::QTY_W-1:0] cell_qhit [kct_pkg::ENTRIES];
    logic [kct_pkg::ENTRIES-1:0]      match_vec;
    logic [kct_pkg::ENTRIES:0]        hit_chain;

    // Control toward the cells
    logic                             go;
    logic                             do_ins;
    logic                             do_acc;
    logic                             do_rem;
    logic                             hit;
    logic                             full;
    logic signed [kct_pkg::QTY_W-1:0] found_qty;
    logic signed [kct_pkg::QTY_W:0]   sum_wide;
    logic signed [kct_pkg::QTY_W-1:0] acc_qty;
    logic signed [kct_pkg::QTY_W-1:0] wr_qty;

    assign req_ready = (state_reg == kct_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Hold the command; drop key bytes beyond KEY_CHARS up front.
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            cmd_reg <= '{req_type: req.req_type,
                         key:      req.key & kct_pkg::KEY_MASK,
                         amount:   req.amount};
        end
    end

    assign hit_chain[0] = 1'b0;
    assign hit          = hit_chain[kct_pkg::ENTRIES];
    assign full         = (count_reg == kct_pkg::CNT_W'(kct_pkg::ENTRIES));

    // Only one valid cell can match, so an OR gathers its quantity.
    always_comb
    begin
        found_qty = '0;
        for (int i = 0; i < kct_pkg::ENTRIES; i++)
        begin
            found_qty = found_qty | cell_qhit[i];
        end
    end

    // Saturating add: overflow when the two top bits of the wide sum differ.
    always_comb
    begin
        sum_wide = {found_qty[kct_pkg::QTY_W-1], found_qty}
                 + {cmd_reg.amount[kct_pkg::QTY_W-1], cmd_reg.amount};
        if (sum_wide[kct_pkg::QTY_W] != sum_wide[kct_pkg::QTY_W-1])
        begin
            acc_qty = sum_wide[kct_pkg::QTY_W]
                    ? {1'b1, {(kct_pkg::QTY_W-1){1'b0}}}
                    : {1'b0, {(kct_pkg::QTY_W-1){1'b1}}};
        end
        else
        begin
            acc_qty = sum_wide[kct_pkg::QTY_W-1:0];
        end
    end

    assign wr_qty = hit ? acc_qty : cmd_reg.amount;

    // ------------------------------------------------------------------
    // Next state and result: the update happens in the execute cycle,
    // and only when the result register is free to take the answer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        go             = 1'b0;
        do_ins         = 1'b0;
        do_acc         = 1'b0;
        do_rem         = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            kct_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = kct_pkg::S_EXEC;
                end
            end
            kct_pkg::S_EXEC:
            begin
                go = !rsp_valid_reg || rsp_ready;
                if (go)
                begin
                    state_next       = kct_pkg::S_IDLE;
                    rsp_valid_next   = 1'b1;
                    rsp_next.status   = kct_pkg::ST_NOTFOUND;
                    rsp_next.quantity = '1;
                    case (cmd_reg.req_type)
                        kct_pkg::REQ_ADD:
                        begin
                            if (hit)
                            begin
                                do_acc            = 1'b1;
                                rsp_next.status   = kct_pkg::ST_ACCUM;
                                rsp_next.quantity = acc_qty;
                            end
                            else if (!full)
                            begin
                                do_ins            = 1'b1;
                                count_next        = count_reg + 1'b1;
                                rsp_next.status   = kct_pkg::ST_INSERT;
                                rsp_next.quantity = cmd_reg.amount;
                            end
                            else
                            begin
                                rsp_next.status   = kct_pkg::ST_FULL;
                                rsp_next.quantity = '0;
                            end
                        end
                        kct_pkg::REQ_REMOVE:
                        begin
                            if (hit)
                            begin
                                do_rem            = 1'b1;
                                count_next        = count_reg - 1'b1;
                                rsp_next.status   = kct_pkg::ST_REMOVED;
                                rsp_next.quantity = '0;
                            end
                        end
                        kct_pkg::REQ_LOOKUP:
                        begin
                            if (hit)
                            begin
                                rsp_next.status   = kct_pkg::ST_FOUND;
                                rsp_next.quantity = found_qty;
                            end
                        end
                        default:
                        begin
                            rsp_next.status   = kct_pkg::ST_NOTFOUND;
                        end
                    endcase
                    rsp_next.entry_count = kct_pkg::COUNT_W'(count_next);
                end
            end
            default:
            begin
                state_next = kct_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kct_pkg::S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload needs no reset; it is qualified by rsp_valid_reg.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // ------------------------------------------------------------------
    // Row of cells. Each cell compares its key against the command, passes
    // the running hit flag upward and, on a remove, takes its upper
    // neighbor's entry so the table stays compact. The top cell refills
    // from itself; it falls outside the fill count after the remove.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < kct_pkg::ENTRIES; i++)
    begin : g_cell
        logic [kct_pkg::KEY_W-1:0]        nb_key;
        logic signed [kct_pkg::QTY_W-1:0] nb_qty;

        if (i + 1 < kct_pkg::ENTRIES)
        begin : g_nb
            assign nb_key = cell_key[i+1];
            assign nb_qty = cell_qty[i+1];
        end
        else
        begin : g_top
            assign nb_key = cell_key[i];
            assign nb_qty = cell_qty[i];
        end

        assign cell_ctl[i].valid  = (kct_pkg::CNT_W'(i) < count_reg);
        assign cell_ctl[i].ins_wr = do_ins && (kct_pkg::CNT_W'(i) == count_reg);
        assign cell_ctl[i].acc_wr = do_acc;
        assign cell_ctl[i].rem_go = do_rem;

        kct_cell u_cell (
            .clk       (clk),
            .ctl       (cell_ctl[i]),
            .cmd_key   (cmd_reg.key),
            .wr_qty    (wr_qty),
            .nb_key    (nb_key),
            .nb_qty    (nb_qty),
            .hit_below (hit_chain[i]),
            .hit_thru  (hit_chain[i+1]),
            .match     (match_vec[i]),
            .key       (cell_key[i]),
            .qty       (cell_qty[i]),
            .qty_hit   (cell_qhit[i])
        );
    end

`ifndef ASSERT_OFF
    // Fill count never passes the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= kct_pkg::CNT_W'(kct_pkg::ENTRIES))
        else $error("fill count beyond table size");

    // Keys stay unique: at most one valid cell matches.
    a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("more than one cell matches the key");

    // An accepted word always moves the sequencer into execute.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == kct_pkg::S_EXEC))
        else $error("accepted word did not start execute");

    // A new result appears only out of an execute cycle.
    a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == kct_pkg::S_EXEC))
        else $error("result raised outside execute");
`endif

endmodule

/* test/keyed_counter_table_test.sv */
// keyed_counter_table_test: self-checking bench for the keyed counter table.
// Holds its own table model, the stimulus tasks and the reply checker.
// Depends on kct_pkg and keyed_counter_table.
`timescale 1ns / 100ps

module keyed_counter_table_test;

    // Command code that the block must treat as a miss without touching the table.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int KEY_POOL    = 24;       // more keys than entries, so the table fills
    localparam int RANDOM_CMDS = 800;
    localparam int CYCLE_LIMIT = 400000;   // far above the worst-case run length

    logic           clk = 1'b0;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    kct_pkg::req_t  req;
    logic           rsp_valid;
    logic           rsp_ready;
    kct_pkg::rsp_t  rsp;

    keyed_counter_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Table model: compact list of keys and counts, plus fill level.
    // ------------------------------------------------------------------
    logic [kct_pkg::KEY_W-1:0]        ledger_key [kct_pkg::ENTRIES];
    logic signed [kct_pkg::QTY_W-1:0] ledger_qty [kct_pkg::ENTRIES];
    int                               ledger_fill;

    kct_pkg::rsp_t awaited_reply [$];     // replies owed by the block, oldest first

    logic [kct_pkg::KEY_W-1:0] key_pool [KEY_POOL];

    int  mismatches;
    int  sent_count;
    int  checked_count;
    int  full_count;
    int  saturate_count;
    int  peak_fill;
    int  cycle_count;
    bit  steady_flow;            // when set, neither side idles

    // Apply one command to the model and return the reply it owes.
    function automatic kct_pkg::rsp_t tally_command(kct_pkg::req_t w);
        kct_pkg::rsp_t             r;
        logic [kct_pkg::KEY_W-1:0] k;
        int                        hit_at;
        longint                    sum;
        k      = w.key & kct_pkg::KEY_MASK;
        hit_at = -1;
        for (int i = 0; i < ledger_fill; i++)
        begin
            if (hit_at < 0 && ledger_key[i] == k)
                hit_at = i;
        end
        r.status   = kct_pkg::ST_NOTFOUND;
        r.quantity = -1;
        case (w.req_type)
            kct_pkg::REQ_ADD:
            begin
                if (hit_at >= 0)
                begin
                    // Clamp the running count at the signed 32-bit limits.
                    sum = longint'(ledger_qty[hit_at]) + longint'(w.amount);
                    if (sum > 64'sd2147483647)
                    begin
                        sum = 64'sd2147483647;
                        saturate_count++;
                    end
                    else if (sum < -64'sd2147483648)
                    begin
                        sum = -64'sd2147483648;
                        saturate_count++;
                    end
                    ledger_qty[hit_at] = kct_pkg::QTY_W'(sum);
                    r.status   = kct_pkg::ST_ACCUM;
                    r.quantity = ledger_qty[hit_at];
                end
                else if (ledger_fill < kct_pkg::ENTRIES)
                begin
                    ledger_key[ledger_fill] = k;
                    ledger_qty[ledger_fill] = w.amount;
                    ledger_fill++;
                    r.status   = kct_pkg::ST_INSERT;
                    r.quantity = w.amount;
                end
                else
                begin
                    r.status   = kct_pkg::ST_FULL;
                    r.quantity = 0;
                    full_count++;
                end
            end
            kct_pkg::REQ_REMOVE:
            begin
                if (hit_at >= 0)
                begin
                    // Close the gap: every later entry moves down one place.
                    for (int j = hit_at; j + 1 < ledger_fill; j++)
                    begin
                        ledger_key[j] = ledger_key[j + 1];
                        ledger_qty[j] = ledger_qty[j + 1];
                    end
                    ledger_fill--;
                    r.status   = kct_pkg::ST_REMOVED;
                    r.quantity = 0;
                end
            end
            kct_pkg::REQ_LOOKUP:
            begin
                if (hit_at >= 0)
                begin
                    r.status   = kct_pkg::ST_FOUND;
                    r.quantity = ledger_qty[hit_at];
                end
            end
            default: ;    // unused code: miss, table untouched
        endcase
        r.entry_count = kct_pkg::COUNT_W'(ledger_fill);
        if (ledger_fill > peak_fill)
            peak_fill = ledger_fill;
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %0s", $realtime, what);
    endtask

    // ------------------------------------------------------------------
    // Request side: idle for a random gap, then hold the word
    // until the block takes it. Valid is left high on return so that a
    // back-to-back word needs no drop in between.
    // ------------------------------------------------------------------
    task automatic send_cmd(input logic [1:0] kind, input logic [kct_pkg::KEY_W-1:0] k,
                            input logic signed [kct_pkg::QTY_W-1:0] amt);
        int            gap;
        kct_pkg::req_t w;
        gap        = steady_flow ? 0 : $urandom_range(0, 12);
        w.req_type = kind;
        w.key      = k;
        w.amount   = amt;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        awaited_reply.push_back(tally_command(w));
        sent_count++;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Reply side: stall at random, take each word, compare it field by
    // field with the oldest owed reply.
    // ------------------------------------------------------------------
    task automatic check_reply(input kct_pkg::rsp_t got);
        kct_pkg::rsp_t want;
        if (awaited_reply.size() == 0)
        begin
            flag_mismatch($sformatf("reply with nothing owed: status %0d qty %0d count %0d",
                                    got.status, got.quantity, got.entry_count));
            return;
        end
        want = awaited_reply.pop_front();
        checked_count++;
        if (got.status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.quantity !== want.quantity)
            flag_mismatch($sformatf("quantity %0d, want %0d", got.quantity, want.quantity));
        if (got.entry_count !== want.entry_count)
            flag_mismatch($sformatf("entry_count %0d, want %0d",
                                    got.entry_count, want.entry_count));
    endtask

    initial
    begin : reply_side
        int stall;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
            check_reply(rsp);
            @(negedge clk);
        end
    end

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies still owed",
                     cycle_count, awaited_reply.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty table: every lookup and remove misses; the unused code misses too.
    task automatic test_empty_table();
        send_cmd(kct_pkg::REQ_LOOKUP, kct_pkg::KEY_W'("BOLTS"), 32'sd5);
        send_cmd(kct_pkg::REQ_REMOVE, kct_pkg::KEY_W'("BOLTS"), 32'sd0);
        send_cmd(REQ_UNUSED, {kct_pkg::KEY_W{1'b1}}, -32'sd1);
    endtask

    // Extreme keys and amounts; push both counts into their limits.
    task automatic test_saturating_counts();
        send_cmd(kct_pkg::REQ_ADD, {kct_pkg::KEY_W{1'b0}}, 32'sh8000_0000);
        send_cmd(kct_pkg::REQ_ADD, {kct_pkg::KEY_W{1'b1}}, 32'sh7FFF_FFFF);
        send_cmd(kct_pkg::REQ_ADD, {kct_pkg::KEY_W{1'b1}}, 32'sd1);
        send_cmd(kct_pkg::REQ_ADD, {kct_pkg::KEY_W{1'b0}}, -32'sd1);
        send_cmd(kct_pkg::REQ_LOOKUP, {kct_pkg::KEY_W{1'b1}}, 32'sd0);
    endtask

    // Fill to the last entry, overflow once, then remove from the middle and
    // the front and look up an entry that moved down.
    task automatic test_fill_and_compact();
        for (int i = 0; i < kct_pkg::ENTRIES - 2; i++)
            send_cmd(kct_pkg::REQ_ADD, 64'h4954_454D_0000_0000 | kct_pkg::KEY_W'(i),
                     kct_pkg::QTY_W'(i * 7 - 40));
        send_cmd(kct_pkg::REQ_ADD, "WIDGET01", 32'sd3);
        send_cmd(kct_pkg::REQ_REMOVE, 64'h4954_454D_0000_0005, 32'sd0);
        send_cmd(kct_pkg::REQ_REMOVE, {kct_pkg::KEY_W{1'b0}}, 32'sd0);
        send_cmd(kct_pkg::REQ_LOOKUP, 64'h4954_454D_0000_000D, 32'sd0);
    endtask

    // Random traffic over a small key pool. Phases lean toward adding or
    // toward removing so the table swings between empty and full.
    task automatic test_random_traffic();
        bit                        filling;
        int                        pick;
        logic [1:0]                kind;
        logic [kct_pkg::KEY_W-1:0] k;
        int                        amt;
        filling = 1'b1;
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = {$urandom, $urandom};
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (n % 100 == 99)
                filling = !filling;
            if (n % 64 == 0)
                steady_flow = ($urandom_range(0, 3) == 0);

            pick = $urandom_range(0, 99);
            if (pick < (filling ? 60 : 25))
                kind = kct_pkg::REQ_ADD;
            else if (pick < (filling ? 72 : 70))
                kind = kct_pkg::REQ_REMOVE;
            else if (pick < 96)
                kind = kct_pkg::REQ_LOOKUP;
            else
                kind = REQ_UNUSED;

            // Mostly pool keys so hits happen; now and then a stranger.
            if ($urandom_range(0, 9) == 0)
                k = {$urandom, $urandom};
            else
                k = key_pool[$urandom_range(0, KEY_POOL - 1)];

            case ($urandom_range(0, 9))
                0: amt = 32'h7FFF_FFFF - $urandom_range(0, 50);
                1: amt = 32'h8000_0000 + $urandom_range(0, 50);
                2: amt = $urandom;
                default: amt = int'($urandom_range(0, 2000)) - 1000;
            endcase

            send_cmd(kind, k, amt);
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin : stimulus
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        ledger_fill = 0;
        mismatches  = 0;
        steady_flow = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_saturating_counts();
        test_fill_and_compact();
        test_random_traffic();

        // Drop valid, drain owed replies, then keep watching for stray replies.
        req_valid <= 1'b0;
        while (awaited_reply.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d commands, %0d replies checked, %0d mismatches",
                 sent_count, checked_count, mismatches);
        $display("table peaked at %0d entries, %0d full replies, %0d saturated adds",
                 peak_fill, full_count, saturate_count);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
